### hw/rtl/rgbcf_pkg.sv
// ----------------------------------------------------------------------------
// rgbcf_pkg
// Shared types, constants and helpers for the RGB crossfade engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbcf_pkg;

   localparam logic       ACTION_START = 1'b0;
   localparam logic       ACTION_TICK  = 1'b1;
   localparam logic [7:0] LEVEL_RESET  = 8'd30;
   localparam logic [7:0] LEVEL_MAX    = 8'd255;
   localparam logic [7:0] LEVEL_MIN    = 8'd0;
   localparam logic [6:0] PCT_MAX      = 7'd100;
   // 255 * ceil(2^19 / 100): exact for every percentage up to 100
   localparam logic [27:0] PCT_SCALE   = 28'd1336965;

   typedef struct packed {
      logic       action;
      logic [6:0] target_red;
      logic [6:0] target_green;
      logic [6:0] target_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
      logic       fading;
      logic       fade_done;
   } rsp_type;

   // Sequencer to lanes: start, tick one cycle pulses; div_step spans ST_DIV
   typedef struct packed {
      logic start;
      logic div_step;
      logic tick;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_RESP
   } state_type;

   // percent to drive level: min(p,100) * 255 / 100, truncated
   function automatic logic [7:0] pct_to_level(input logic [6:0] pct);
      logic [6:0]  sat;
      logic [27:0] prod;
      sat  = (pct > PCT_MAX) ? PCT_MAX : pct;
      prod = 28'(sat) * PCT_SCALE;
      return prod[26:19];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rgb_crossfade_engine_top.sv
// ----------------------------------------------------------------------------
// rgb_crossfade_engine_top
// Three-channel LED crossfade engine: lanes per colour plus result merge.
// ----------------------------------------------------------------------------
// Usage:
//  req channel carries a start (targets in percent, above 100 saturate) or a
//  tick. Every request produces exactly one rsp transfer with the three
//  levels, fading and fade_done.
//  A start runs a bit-serial step division in all three lanes at once, one
//  quotient bit per cycle, IdxW = clog2(FADE_STEPS+1) bits (10 at 1020).
//  rsp_valid rises once the merge state loads the output register, after
//  the division for a start and straight from idle for a tick.
//  A new request is taken only after the previous one has left the merge
//  state; the division sequencer is the limit.
//  req_ready is high while the sequencer is idle, also while a result waits
//  in the output register; a finished item waits for that register to drain
//  if the receiver stalls, and req_ready stays low meanwhile.
//  Reset: levels 30, no fade running, output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_crossfade_engine_top #(
   parameter int FADE_STEPS = 1020
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  rgbcf_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output rgbcf_pkg::rsp_type   rsp_data
);
   import rgbcf_pkg::*;

   localparam int IdxW = $clog2(FADE_STEPS + 1);
   localparam int CntW = $clog2(IdxW + 1);

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [IdxW-1:0] tick_ff, tick_in;
   logic            active_ff, active_in;
   logic            done_ff, done_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   ctl_type         ctl;
   logic            req_fire;
   logic [7:0]      lvl_red, lvl_green, lvl_blue;

   rgbcf_lane #(.FADE_STEPS(FADE_STEPS)) u_lane_red (
      .clock(clock), .reset(reset), .ctl(ctl),
      .target_pct(req_data.target_red), .level(lvl_red)
   );
   rgbcf_lane #(.FADE_STEPS(FADE_STEPS)) u_lane_green (
      .clock(clock), .reset(reset), .ctl(ctl),
      .target_pct(req_data.target_green), .level(lvl_green)
   );
   rgbcf_lane #(.FADE_STEPS(FADE_STEPS)) u_lane_blue (
      .clock(clock), .reset(reset), .ctl(ctl),
      .target_pct(req_data.target_blue), .level(lvl_blue)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tick_in      = tick_ff;
      active_in    = active_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ctl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.action == ACTION_START) begin
                  ctl.start = 1'b1;
                  active_in = 1'b1;
                  done_in   = 1'b0;
                  tick_in   = '0;
                  cnt_in    = CntW'(IdxW - 1);
                  state_in  = ST_DIV;
               end else begin
                  done_in = 1'b0;
                  if (active_ff) begin
                     ctl.tick = 1'b1;
                     if (tick_ff >= IdxW'(FADE_STEPS)) begin
                        done_in   = 1'b1;
                        active_in = 1'b0;
                        tick_in   = '0;
                     end else begin
                        tick_in = tick_ff + IdxW'(1);
                     end
                  end
                  state_in = ST_RESP;
               end
            end
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            cnt_in       = cnt_ff - CntW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // merge lane levels into one result once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.red_level   = lvl_red;
               rsp_data_in.green_level = lvl_green;
               rsp_data_in.blue_level  = lvl_blue;
               rsp_data_in.fading      = active_ff;
               rsp_data_in.fade_done   = done_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         active_ff    <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         active_ff    <= active_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_start_divides: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.action == ACTION_START) |=> state_ff == ST_DIV)
      else $error("start transfer did not enter division");

   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      tick_ff <= IdxW'(FADE_STEPS))
      else $error("tick index beyond fade length");

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> tick_ff == '0)
      else $error("tick index not cleared while no fade runs");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.fade_done) |-> !rsp_data_ff.fading)
      else $error("fade reported done while still fading");

   a_resp_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("merged result not presented");

endmodule

`default_nettype wire

### hw/rtl/rgbcf_lane.sv
// ----------------------------------------------------------------------------
// rgbcf_lane
// One colour channel: level register, step divider and step phase counter.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbcf_lane #(
   parameter int FADE_STEPS = 1020
) (
   input  wire                  clock,
   input  wire                  reset,
   input  rgbcf_pkg::ctl_type   ctl,
   input  wire  [6:0]           target_pct,
   output logic [7:0]           level
);
   import rgbcf_pkg::*;

   localparam int IdxW = $clog2(FADE_STEPS + 1);

   logic [7:0]      level_ff, level_in;
   logic            up_ff, up_in;
   logic            still_ff, still_in;
   logic [7:0]      div_ff, div_in;
   logic [7:0]      rem_ff, rem_in;
   logic [IdxW-1:0] quo_ff, quo_in;
   logic [IdxW-1:0] phase_ff, phase_in;

   logic [7:0]      tgt_level;
   logic [8:0]      trial;
   logic            fits;
   logic [IdxW:0]   phase_next;
   logic            move;

   assign tgt_level  = pct_to_level(target_pct);
   // restoring division: dividend shifts out of quo_ff as quotient bits shift in
   assign trial      = {rem_ff, quo_ff[IdxW-1]};
   assign fits       = trial >= {1'b0, div_ff};
   assign phase_next = {1'b0, phase_ff} + (IdxW+1)'(1);
   assign move       = !still_ff && (phase_ff == '0);

   always_comb begin
      level_in = level_ff;
      up_in    = up_ff;
      still_in = still_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      phase_in = phase_ff;
      if (ctl.start) begin
         up_in    = tgt_level > level_ff;
         still_in = tgt_level == level_ff;
         div_in   = (tgt_level > level_ff) ? (tgt_level - level_ff) : (level_ff - tgt_level);
         rem_in   = '0;
         quo_in   = IdxW'(FADE_STEPS);
         phase_in = '0;
      end else if (ctl.div_step) begin
         rem_in = fits ? 8'(trial - {1'b0, div_ff}) : trial[7:0];
         quo_in = {quo_ff[IdxW-2:0], fits};
      end else if (ctl.tick) begin
         // phase tracks tick index modulo step magnitude
         phase_in = (phase_next == {1'b0, quo_ff}) ? '0 : phase_next[IdxW-1:0];
         if (move) begin
            if (up_ff) begin
               level_in = (level_ff == LEVEL_MAX) ? level_ff : level_ff + 8'd1;
            end else begin
               level_in = (level_ff == LEVEL_MIN) ? level_ff : level_ff - 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
         still_ff <= 1'b1;
         phase_ff <= '0;
      end else begin
         level_ff <= level_in;
         still_ff <= still_in;
         phase_ff <= phase_in;
      end
      up_ff  <= up_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign level = level_ff;

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB crossfade engine. A short table of starts
// and ticks comes first, then random fades: the first completes, others
// are mostly cut short by a new start, with noise mixed in. Each request is
// run through a model of the fade. Every rsp transfer is checked field by
// field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import rgbcf_pkg::*;

   localparam int FADE_STEPS   = 1020;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 30;
   localparam int RAND_ITEMS   = 1600;
   localparam int IDLE_PCT     = 11;

   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type want;
   } dir_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   always #10 clock = ~clock;

   rgb_crossfade_engine_top #(.FADE_STEPS(FADE_STEPS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // model of the fade state
   logic [7:0]         lvl [3];
   logic signed [11:0] stp [3];
   logic [10:0]        tick_idx;
   bit                 fade_on;

   rsp_type     levels_due [$];
   dir_row_type dir_rows [$];
   int          mismatches;
   int          item_count;
   int          idle_cycles;
   bit          calm;

   function automatic logic [7:0] pct_level(logic [6:0] p);
      int v;
      v = (p > PCT_MAX) ? 100 : int'(p);
      return 8'((v * 255) / 100);
   endfunction

   function automatic logic signed [11:0] fade_step(logic [7:0] cur, logic [7:0] tgt);
      int gap;
      gap = int'(tgt) - int'(cur);
      if (gap == 0)
         return '0;
      return 12'(FADE_STEPS / gap);
   endfunction

   function automatic logic [7:0] step_level(logic signed [11:0] s, logic [7:0] v, int i);
      int n;
      int mag;
      n = int'(v);
      if (s != 0) begin
         mag = (s < 0) ? -int'(s) : int'(s);
         if (i % mag == 0)
            n += (s > 0) ? 1 : -1;
      end
      if (n > 255)
         n = 255;
      else if (n < 0)
         n = 0;
      return 8'(n);
   endfunction

   function rsp_type predict_levels(req_type r);
      bit      done;
      int      i;
      rsp_type o;
      done = 1'b0;
      if (r.action == ACTION_START) begin
         stp[0]   = fade_step(lvl[0], pct_level(r.target_red));
         stp[1]   = fade_step(lvl[1], pct_level(r.target_green));
         stp[2]   = fade_step(lvl[2], pct_level(r.target_blue));
         tick_idx = '0;
         fade_on  = 1'b1;
      end else if (fade_on) begin
         i = int'(tick_idx);
         for (int k = 0; k < 3; k++)
            lvl[k] = step_level(stp[k], lvl[k], i);
         if (i >= FADE_STEPS) begin
            done     = 1'b1;
            fade_on  = 1'b0;
            tick_idx = '0;
         end else begin
            tick_idx = 11'(i + 1);
         end
      end
      o.red_level   = lvl[0];
      o.green_level = lvl[1];
      o.blue_level  = lvl[2];
      o.fading      = fade_on;
      o.fade_done   = done;
      return o;
   endfunction

   task automatic flag_mismatch(string what);
      mismatches++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   function automatic void add_row(logic act, logic [6:0] tr, logic [6:0] tg, logic [6:0] tb_,
                                   bit fixed, logic [7:0] wr = 8'd0, logic [7:0] wg = 8'd0,
                                   logic [7:0] wb = 8'd0, logic wf = 1'b0, logic wd = 1'b0);
      dir_row_type row;
      row.req.action       = act;
      row.req.target_red   = tr;
      row.req.target_green = tg;
      row.req.target_blue  = tb_;
      row.fixed            = fixed;
      row.want.red_level   = wr;
      row.want.green_level = wg;
      row.want.blue_level  = wb;
      row.want.fading      = wf;
      row.want.fade_done   = wd;
      dir_rows.push_back(row);
   endfunction

   function automatic logic [6:0] rand_pct();
      case ($urandom_range(0, 7))
         0:       return 7'd0;
         1:       return PCT_MAX;
         2:       return 7'd127;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   // entered and left at a falling edge; valid is left high for the next item
   task automatic send_item(req_type r, bit fixed, rsp_type want);
      rsp_type exp_lv;
      calm = (item_count >= 400 && item_count < 900);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      exp_lv = predict_levels(r);
      if (fixed)
         exp_lv = want;
      levels_due.push_back(exp_lv);
      item_count++;
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (levels_due.size() != 0)
         @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (levels_due.size() == 0) begin
            flag_mismatch("rsp transfer with nothing expected");
         end else begin
            want = levels_due.pop_front();
            check_field("red_level",   rsp_data.red_level,   want.red_level);
            check_field("green_level", rsp_data.green_level, want.green_level);
            check_field("blue_level",  rsp_data.blue_level,  want.blue_level);
            check_field("fading",      8'(rsp_data.fading),    8'(want.fading));
            check_field("fade_done",   8'(rsp_data.fade_done), 8'(want.fade_done));
         end
      end
   end

   // watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      req_type r;
      rsp_type none;
      int      n_ticks;
      int      seq;
      none = '0;

      lvl        = '{LEVEL_RESET, LEVEL_RESET, LEVEL_RESET};
      stp        = '{12'sd0, 12'sd0, 12'sd0};
      tick_idx   = '0;
      fade_on    = 1'b0;
      mismatches = 0;
      item_count = 0;
      calm       = 1'b0;

      // idle ticks report reset levels; target fields are ignored on a tick
      add_row(ACTION_TICK,  7'd0,   7'd0,   7'd0,   1'b1, 8'd30, 8'd30, 8'd30, 1'b0, 1'b0);
      add_row(ACTION_TICK,  7'd127, 7'd127, 7'd127, 1'b1, 8'd30, 8'd30, 8'd30, 1'b0, 1'b0);
      // over-range red saturates, green to zero, blue 12% equals level 30
      add_row(ACTION_START, 7'd127, 7'd0,   7'd12,  1'b1, 8'd30, 8'd30, 8'd30, 1'b1, 1'b0);
      repeat (5) add_row(ACTION_TICK, 7'd85, 7'd42, 7'd0, 1'b0);
      // restart mid fade from the current levels
      add_row(ACTION_START, 7'd100, 7'd100, 7'd100, 1'b0);
      repeat (3) add_row(ACTION_TICK, 7'd0, 7'd0, 7'd0, 1'b0);
      add_row(ACTION_START, 7'd0,   7'd0,   7'd0,   1'b0);
      repeat (3) add_row(ACTION_TICK, 7'd0, 7'd0, 7'd0, 1'b0);
      add_row(ACTION_START, 7'd64,  7'd63,  7'd1,   1'b0);
      repeat (2) add_row(ACTION_TICK, 7'd0, 7'd0, 7'd0, 1'b0);
      add_row(ACTION_START, 7'd101, 7'd50,  7'd99,  1'b0);
      add_row(ACTION_TICK,  7'd0,   7'd0,   7'd0,   1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[k])
         send_item(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].want);
      hold_until_drained();

      // random fades: the first runs to or past completion, the rest mostly short
      seq = 0;
      while (item_count < RAND_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5)) begin
               r.action       = 1'($urandom_range(0, 1));
               r.target_red   = rand_pct();
               r.target_green = rand_pct();
               r.target_blue  = rand_pct();
               send_item(r, 1'b0, none);
            end
         end
         r.action       = ACTION_START;
         r.target_red   = rand_pct();
         r.target_green = rand_pct();
         r.target_blue  = rand_pct();
         send_item(r, 1'b0, none);
         if (seq == 0 || ($urandom_range(0, 4) == 0 &&
                          item_count + FADE_STEPS + 4 < RAND_ITEMS))
            n_ticks = FADE_STEPS + 1 + $urandom_range(0, 3);
         else
            n_ticks = $urandom_range(0, 80);
         repeat (n_ticks) begin
            r.action       = ACTION_TICK;
            r.target_red   = 7'($urandom_range(0, 127));
            r.target_green = 7'($urandom_range(0, 127));
            r.target_blue  = 7'($urandom_range(0, 127));
            send_item(r, 1'b0, none);
         end
         seq++;
         if (seq == 3)
            hold_until_drained();
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (levels_due.size() != 0)
         flag_mismatch("expected results left over");
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### rgb_crossfade_engine_top.f
hw/rtl/rgbcf_pkg.sv
hw/rtl/rgbcf_lane.sv
hw/rtl/rgb_crossfade_engine_top.sv
test/tb.sv
